/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/i2cms_pkg.sv */
// Types, codes and constants of the I2C master transaction sequencer.
`default_nettype none

package i2cms_pkg;

    // Transmit queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Configuration register indexes
    localparam logic [1:0] CFG_MASTER_MODE   = 2'd0;
    localparam logic [1:0] CFG_TICK_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd2;

    // Configuration reset values
    localparam logic        MASTER_MODE_RST   = 1'b1;
    localparam logic [15:0] TICK_LIMIT_RST    = 16'd10000;
    localparam logic [7:0]  SLAVE_ADDRESS_RST = 8'd160;

    // Status codes beyond the phase numbers
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ERR_OFFSET = 5'd8;

    // Input transaction kinds
    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_BEGIN = 2'd1,
        FN_POLL  = 2'd2,
        FN_NOP   = 2'd3
    } func_t;

    // Sequencer phases; the number doubles as the wait status
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_BUSY    = 4'd1,
        PH_START   = 4'd2,
        PH_ADDR_W  = 4'd3,
        PH_SENT    = 4'd4,
        PH_FINISH  = 4'd5,
        PH_RESTART = 4'd6,
        PH_ADDR_R  = 4'd7,
        PH_RECV    = 4'd8
    } phase_t;

    // Bus actions reported on the result channel
    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_START   = 4'd1,
        ACT_ADDR_W  = 4'd2,
        ACT_ADDR_R  = 4'd3,
        ACT_SEND    = 4'd4,
        ACT_ACK_ON  = 4'd5,
        ACT_ACK_OFF = 4'd6,
        ACT_STOP    = 4'd7,
        ACT_RECV    = 4'd8
    } action_t;

    // Bus flag bit positions
    localparam int FLAG_BUSY      = 0;
    localparam int FLAG_START     = 1;
    localparam int FLAG_ADDR_W    = 2;
    localparam int FLAG_SENT      = 3;
    localparam int FLAG_FINISHED  = 4;
    localparam int FLAG_ADDR_R    = 5;
    localparam int FLAG_RECEIVED  = 6;

    // One input transaction
    typedef struct packed {
        func_t      func;
        logic [3:0] tx_index;
        logic [7:0] tx_byte;
        logic [4:0] send_count;
        logic [4:0] receive_count;
        logic [6:0] bus_flags;
        logic [7:0] rx_byte;
    } in_item_t;

    // One result transaction
    typedef struct packed {
        action_t    action;
        logic [7:0] action_byte;
        logic [3:0] action_index;
        logic [4:0] status;
        logic [4:0] bytes_written;
        logic [4:0] bytes_read;
        logic       last;
    } out_item_t;

    // Configuration write
    typedef struct packed {
        logic        wr;
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

/* rtl/i2cms_core.sv */
// Sequencer state, transmit queue and per-transaction next-state logic.
`default_nettype none

module i2cms_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire i2cms_pkg::cfg_wr_t   cfg,
    input  wire logic                 accept,
    input  wire i2cms_pkg::in_item_t  item,
    output i2cms_pkg::out_item_t      res0,
    output i2cms_pkg::out_item_t      res1,
    output logic                      two
);
    import i2cms_pkg::*;

    // Configuration registers
    logic        master_mode_reg;
    logic [15:0] tick_limit_reg;
    logic [7:0]  slave_address_reg;

    // Sequencer state
    phase_t      phase_reg, phase_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic [CNT_W-1:0] pend_send_reg, pend_send_next;
    logic [CNT_W-1:0] pend_recv_reg, pend_recv_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [4:0]  status_reg, status_next;
    logic [CNT_W-1:0] written_reg, written_next;
    logic [CNT_W-1:0] read_reg, read_next;

    logic [7:0]  queue_reg [QUEUE_DEPTH];

    action_t     act0, act1;
    logic [7:0]  abyte0, abyte1;
    logic [3:0]  aidx0;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_mode_reg   <= MASTER_MODE_RST;
            tick_limit_reg    <= TICK_LIMIT_RST;
            slave_address_reg <= SLAVE_ADDRESS_RST;
        end
        else if (cfg.wr)
        begin
            case (cfg.index)
                CFG_MASTER_MODE:   master_mode_reg   <= cfg.data[0];
                CFG_TICK_LIMIT:    tick_limit_reg    <= cfg.data;
                CFG_SLAVE_ADDRESS: slave_address_reg <= cfg.data[7:0];
                default:           ;
            endcase
        end
    end

    // Load transmit queue slots
    always_ff @(posedge clk)
    begin
        if (accept && item.func == FN_LOAD)
            queue_reg[item.tx_index[IDX_W-1:0]] <= item.tx_byte;
    end

    // Hold sequencer state between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            pend_send_reg <= '0;
            pend_recv_reg <= '0;
            pos_reg       <= '0;
            status_reg    <= ST_IDLE;
            written_reg   <= '0;
            read_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            pend_send_reg <= pend_send_next;
            pend_recv_reg <= pend_recv_next;
            pos_reg       <= pos_next;
            status_reg    <= status_next;
            written_reg   <= written_next;
            read_reg      <= read_next;
        end
    end

    // Decide next state and bus actions for one transaction
    always_comb
    begin
        phase_t           ph;
        logic             go;
        logic             met;
        logic [16:0]      el;
        logic [CNT_W-1:0] cnt;

        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        pend_send_next = pend_send_reg;
        pend_recv_next = pend_recv_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        written_next   = written_reg;
        read_next      = read_reg;
        act0   = ACT_NONE;
        abyte0 = '0;
        aidx0  = '0;
        act1   = ACT_NONE;
        abyte1 = '0;
        two    = 1'b0;
        ph     = phase_reg;
        go     = 1'b0;
        met    = 1'b0;
        el     = elapsed_reg;
        cnt    = '0;

        case (item.func)
            FN_BEGIN:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    pend_send_next = (item.send_count > CNT_W'(QUEUE_DEPTH))
                                   ? CNT_W'(QUEUE_DEPTH) : item.send_count;
                    pend_recv_next = (item.receive_count > CNT_W'(QUEUE_DEPTH))
                                   ? CNT_W'(QUEUE_DEPTH) : item.receive_count;
                    written_next   = '0;
                    read_next      = '0;
                end
            end
            FN_POLL:
            begin
                go = 1'b1;
                // Start a transaction from idle, or just clear in slave mode
                if (phase_reg == PH_IDLE)
                begin
                    if (!master_mode_reg)
                    begin
                        go             = 1'b0;
                        status_next    = ST_IDLE;
                        elapsed_next   = '0;
                        pend_send_next = '0;
                        pend_recv_next = '0;
                    end
                    else if (pend_send_reg == '0 && pend_recv_reg == '0)
                        go = 1'b0;
                    else
                    begin
                        ph = PH_BUSY;
                        el = '0;
                    end
                end

                if (go)
                begin
                    case (ph)
                        PH_BUSY:    met = !item.bus_flags[FLAG_BUSY];
                        PH_START:   met = item.bus_flags[FLAG_START];
                        PH_ADDR_W:  met = item.bus_flags[FLAG_ADDR_W];
                        PH_SENT:    met = item.bus_flags[FLAG_SENT];
                        PH_FINISH:  met = item.bus_flags[FLAG_FINISHED];
                        PH_RESTART: met = item.bus_flags[FLAG_START];
                        PH_ADDR_R:  met = item.bus_flags[FLAG_ADDR_R];
                        PH_RECV:    met = item.bus_flags[FLAG_RECEIVED];
                        default:    met = 1'b0;
                    endcase

                    // Enter the next wait unless a branch below finishes
                    phase_next   = ph;
                    status_next  = 5'(ph);
                    elapsed_next = '0;

                    if (!met)
                    begin
                        if (el > {1'b0, tick_limit_reg})
                        begin
                            phase_next     = PH_IDLE;
                            status_next    = 5'(ph) + ERR_OFFSET;
                            pend_send_next = '0;
                            pend_recv_next = '0;
                        end
                        else
                            elapsed_next = el + 17'd1;
                    end
                    else
                    begin
                        case (ph)
                            PH_BUSY, PH_FINISH:
                            begin
                                if (ph == PH_BUSY && pend_send_reg != '0)
                                begin
                                    act0       = ACT_START;
                                    phase_next = PH_START;
                                end
                                else if (pend_recv_reg != '0)
                                begin
                                    act0       = ACT_ACK_ON;
                                    act1       = ACT_START;
                                    two        = 1'b1;
                                    phase_next = PH_RESTART;
                                end
                                else
                                begin
                                    // Write-only transaction done
                                    act0           = ACT_STOP;
                                    phase_next     = PH_IDLE;
                                    pend_send_next = '0;
                                    pend_recv_next = '0;
                                end
                            end
                            PH_START:
                            begin
                                act0       = ACT_ADDR_W;
                                abyte0     = {slave_address_reg[7:1], 1'b0};
                                phase_next = PH_ADDR_W;
                            end
                            PH_ADDR_W:
                            begin
                                pos_next   = '0;
                                act0       = ACT_SEND;
                                abyte0     = queue_reg[0];
                                phase_next = PH_SENT;
                            end
                            PH_SENT:
                            begin
                                cnt          = pos_reg + CNT_W'(1);
                                written_next = cnt;
                                pos_next     = cnt;
                                if (cnt < pend_send_reg && cnt < CNT_W'(QUEUE_DEPTH))
                                begin
                                    act0       = ACT_SEND;
                                    abyte0     = queue_reg[cnt[IDX_W-1:0]];
                                    phase_next = PH_SENT;
                                end
                                else
                                    phase_next = PH_FINISH;
                            end
                            PH_RESTART:
                            begin
                                act0       = ACT_ADDR_R;
                                abyte0     = {slave_address_reg[7:1], 1'b1};
                                phase_next = PH_ADDR_R;
                            end
                            PH_ADDR_R:
                            begin
                                pos_next = '0;
                                if (pend_recv_reg == CNT_W'(1))
                                    act0 = ACT_ACK_OFF;
                                phase_next = PH_RECV;
                            end
                            PH_RECV:
                            begin
                                act0      = ACT_RECV;
                                abyte0    = item.rx_byte;
                                aidx0     = 4'(pos_reg);
                                cnt       = pos_reg + CNT_W'(1);
                                read_next = cnt;
                                pos_next  = cnt;
                                if (cnt < pend_recv_reg)
                                begin
                                    // Drop ACK ahead of the final byte
                                    if (cnt + CNT_W'(1) == pend_recv_reg)
                                    begin
                                        act1 = ACT_ACK_OFF;
                                        two  = 1'b1;
                                    end
                                    phase_next = PH_RECV;
                                end
                                else
                                begin
                                    act1           = ACT_STOP;
                                    two            = 1'b1;
                                    phase_next     = PH_IDLE;
                                    pend_send_next = '0;
                                    pend_recv_next = '0;
                                end
                            end
                            default:
                            begin
                                phase_next     = PH_IDLE;
                                pend_send_next = '0;
                                pend_recv_next = '0;
                            end
                        endcase
                        status_next = 5'(phase_next);
                    end
                end
            end
            default: ;
        endcase
    end

    // Build the result transactions from the post-update counters
    always_comb
    begin
        res0.action        = act0;
        res0.action_byte   = abyte0;
        res0.action_index  = aidx0;
        res0.status        = status_next;
        res0.bytes_written = 5'(written_next);
        res0.bytes_read    = 5'(read_next);
        res0.last          = !two;

        res1.action        = act1;
        res1.action_byte   = abyte1;
        res1.action_index  = '0;
        res1.status        = status_next;
        res1.bytes_written = 5'(written_next);
        res1.bytes_read    = 5'(read_next);
        res1.last          = 1'b1;
    end

endmodule

`default_nettype wire

/* rtl/i2c_master_transaction_sequencer.sv */
// I2C master transaction sequencer: stream front end and result buffer.
//
// Usage: each input transaction on the s_ group is a queue load, a begin
// (counts for the write and read phases) or a poll tick carrying the bus
// flags and the received data register. Every input transaction returns one
// or two result transactions on the m_ group; tlast marks the final one.
// The cfg channel writes master_mode (0), tick_limit (1), slave_address (2);
// cfg_ready is always high and writes are meant for idle periods.
// Results are registered: a result appears in the cycle after its input is accepted.
// Throughput: one input per cycle while m_tready is high and inputs return single results;
// one with two holds off the next until its first drains; the two-entry buffer sets this.
// Reset (rst_n low, asynchronous) clears the phase, counters, status and
// buffer and loads the configuration defaults; queue contents stay unknown
// until loaded. When the receiver stalls, the buffered result holds and
// s_tready drops until the buffer can take the next input's results.
`default_nettype none
`include "assert_macros.svh"

module i2c_master_transaction_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // tx_index[3:0], tx_byte[11:4], send_count[16:12],
                                       // receive_count[21:17], bus_flags[28:22],
                                       // rx_byte[36:29], zero fill [39:37]
    input  wire logic [1:0]  s_tuser,  // func[1:0]
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // action_byte[7:0], action_index[11:8], status[16:12],
                                       // bytes_written[21:17], bytes_read[26:22],
                                       // zero fill [31:27]
    output logic [3:0]       m_tuser,  // action[3:0]
    output logic             m_tlast,
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import i2cms_pkg::*;

    in_item_t  item;
    cfg_wr_t   cfg;
    out_item_t res0, res1;
    logic      two;
    logic      accept;
    logic      take;

    out_item_t slot0_reg, slot1_reg;
    logic      valid0_reg, valid1_reg;

    // Unpack the input transaction
    always_comb
    begin
        item.func          = func_t'(s_tuser);
        item.tx_index      = s_tdata[3:0];
        item.tx_byte       = s_tdata[11:4];
        item.send_count    = s_tdata[16:12];
        item.receive_count = s_tdata[21:17];
        item.bus_flags     = s_tdata[28:22];
        item.rx_byte       = s_tdata[36:29];
    end

    assign cfg_ready = 1'b1;
    assign cfg       = '{wr: cfg_valid && cfg_ready, index: cfg_index, data: cfg_data};

    // Take a new input when the buffer drains this cycle or is empty
    assign take     = valid0_reg && m_tready;
    assign s_tready = !valid0_reg || (m_tready && !valid1_reg);
    assign accept   = s_tvalid && s_tready;

    i2cms_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .item   (item),
        .res0   (res0),
        .res1   (res1),
        .two    (two)
    );

    // Track occupancy of the two result slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid0_reg <= 1'b1;
            valid1_reg <= two;
        end
        else if (take)
        begin
            valid0_reg <= valid1_reg;
            valid1_reg <= 1'b0;
        end
    end

    // Load or advance result payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
        else if (take && valid1_reg)
            slot0_reg <= slot1_reg;
    end

    // Drive the result stream
    assign m_tvalid = valid0_reg;
    assign m_tuser  = slot0_reg.action;
    assign m_tlast  = slot0_reg.last;
    assign m_tdata  = {5'd0, slot0_reg.bytes_read, slot0_reg.bytes_written,
                       slot0_reg.status, slot0_reg.action_index, slot0_reg.action_byte};

    // Checks on the result buffer
    `ASSERT_IMPL(a_slot_order, clk, rst_n, valid1_reg, valid0_reg,
                 "second result slot filled while first slot empty")
    `ASSERT_IMPL(a_accept_room, clk, rst_n, accept && valid0_reg,
                 m_tready && !valid1_reg, "input taken while result buffer full")
    `ASSERT_NEXT(a_tail_follows, clk, rst_n, m_tvalid && m_tready && !m_tlast,
                 m_tvalid && m_tlast, "final result of a transaction missing")

endmodule

`default_nettype wire

/* sim/i2c_master_transaction_sequencer_tb.sv */
// Self-checking testbench for the I2C master transaction sequencer stream block.
module i2c_master_transaction_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cms_pkg::*;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int STALL_LIMIT    = 2000;
    localparam int PHASE_ITEMS    = 150;
    localparam int MAX_REPORTS    = 100;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    i2c_master_transaction_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Sequencer copy: configuration
    logic        mode_q;
    logic [15:0] limit_q;
    logic [7:0]  addr_q;

    // Sequencer copy: state
    phase_t      seq_phase;
    logic [16:0] ticks;
    logic [7:0]  tx_queue [QUEUE_DEPTH];
    logic [4:0]  want_send;
    logic [4:0]  want_recv;
    logic [4:0]  pos;
    logic [4:0]  status_q;
    logic [4:0]  wr_cnt;
    logic [4:0]  rd_cnt;

    out_item_t   step_actions[$];
    out_item_t   expected_results[$];

    int          mismatches = 0;
    int          items_sent = 0;
    int          hit_pct = 80;
    bit          idle_on = 1'b1;
    int          ready_stall = 0;
    int          quiet_cycles = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Bus action bookkeeping for the current transaction
    function automatic void emit_action(action_t a, logic [7:0] b, logic [3:0] idx);
        step_actions.push_back('{a, b, idx, 5'd0, 5'd0, 5'd0, 1'b0});
    endfunction

    function automatic void enter_phase(phase_t p);
        seq_phase = p;
        status_q  = 5'(p);
        ticks     = '0;
    endfunction

    function automatic void end_transfer(logic [4:0] st);
        seq_phase = PH_IDLE;
        status_q  = st;
        ticks     = '0;
        want_send = '0;
        want_recv = '0;
    endfunction

    function automatic void start_read();
        emit_action(ACT_ACK_ON, 8'h00, 4'h0);
        emit_action(ACT_START, 8'h00, 4'h0);
        enter_phase(PH_RESTART);
    endfunction

    // One poll tick of the sequencer
    function automatic void step_poll(logic [6:0] f, logic [7:0] rx);
        logic met;
        if (seq_phase == PH_IDLE)
        begin
            if (!mode_q)
            begin
                end_transfer(ST_IDLE);
                return;
            end
            if (want_send == 0 && want_recv == 0)
                return;
            enter_phase(PH_BUSY);
        end
        case (seq_phase)
            PH_BUSY:    met = !f[FLAG_BUSY];
            PH_START:   met = f[FLAG_START];
            PH_ADDR_W:  met = f[FLAG_ADDR_W];
            PH_SENT:    met = f[FLAG_SENT];
            PH_FINISH:  met = f[FLAG_FINISHED];
            PH_RESTART: met = f[FLAG_START];
            PH_ADDR_R:  met = f[FLAG_ADDR_R];
            PH_RECV:    met = f[FLAG_RECEIVED];
            default:
            begin
                end_transfer(ST_IDLE);
                return;
            end
        endcase
        // Count a failed wait, or give up once past the limit
        if (!met)
        begin
            if (ticks > {1'b0, limit_q})
                end_transfer(5'(seq_phase) + ERR_OFFSET);
            else
                ticks = ticks + 17'd1;
            return;
        end
        // Advance on a met wait
        case (seq_phase)
            PH_BUSY:
                if (want_send != 0)
                begin
                    emit_action(ACT_START, 8'h00, 4'h0);
                    enter_phase(PH_START);
                end
                else
                    start_read();
            PH_START:
            begin
                emit_action(ACT_ADDR_W, addr_q & 8'hFE, 4'h0);
                enter_phase(PH_ADDR_W);
            end
            PH_ADDR_W:
            begin
                pos = '0;
                emit_action(ACT_SEND, tx_queue[0], 4'h0);
                enter_phase(PH_SENT);
            end
            PH_SENT:
            begin
                wr_cnt = pos + 5'd1;
                pos    = wr_cnt;
                if (pos < want_send && pos < QUEUE_DEPTH)
                begin
                    emit_action(ACT_SEND, tx_queue[pos[3:0]], 4'h0);
                    enter_phase(PH_SENT);
                end
                else
                    enter_phase(PH_FINISH);
            end
            PH_FINISH:
                if (want_recv != 0)
                    start_read();
                else
                begin
                    emit_action(ACT_STOP, 8'h00, 4'h0);
                    end_transfer(ST_IDLE);
                end
            PH_RESTART:
            begin
                emit_action(ACT_ADDR_R, addr_q | 8'h01, 4'h0);
                enter_phase(PH_ADDR_R);
            end
            PH_ADDR_R:
            begin
                pos = '0;
                if (want_recv == 5'd1)
                    emit_action(ACT_ACK_OFF, 8'h00, 4'h0);
                enter_phase(PH_RECV);
            end
            default:
            begin
                emit_action(ACT_RECV, rx, pos[3:0]);
                rd_cnt = pos + 5'd1;
                pos    = rd_cnt;
                if (pos < want_recv)
                begin
                    if (pos + 5'd1 == want_recv)
                        emit_action(ACT_ACK_OFF, 8'h00, 4'h0);
                    enter_phase(PH_RECV);
                end
                else
                begin
                    emit_action(ACT_STOP, 8'h00, 4'h0);
                    end_transfer(ST_IDLE);
                end
            end
        endcase
    endfunction

    // Work out the results of one accepted input transaction
    function automatic void predict_results(in_item_t it);
        out_item_t r;
        step_actions.delete();
        case (it.func)
            FN_LOAD:
                tx_queue[it.tx_index] = it.tx_byte;
            FN_BEGIN:
                if (seq_phase == PH_IDLE)
                begin
                    want_send = (it.send_count > QUEUE_DEPTH) ? 5'(QUEUE_DEPTH) : it.send_count;
                    want_recv = (it.receive_count > QUEUE_DEPTH) ?
                                5'(QUEUE_DEPTH) : it.receive_count;
                    wr_cnt    = '0;
                    rd_cnt    = '0;
                end
            FN_POLL:
                step_poll(it.bus_flags, it.rx_byte);
            default: ;
        endcase
        if (step_actions.size() == 0)
            emit_action(ACT_NONE, 8'h00, 4'h0);
        foreach (step_actions[k])
        begin
            r               = step_actions[k];
            r.status        = status_q;
            r.bytes_written = wr_cnt;
            r.bytes_read    = rd_cnt;
            r.last          = (k == step_actions.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Check each result transaction and drive receiver stalls
    always @(posedge clk)
    begin : result_check
        out_item_t got;
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{action_t'(m_tuser), m_tdata[7:0], m_tdata[11:8], m_tdata[16:12],
                    m_tdata[21:17], m_tdata[26:22], m_tlast};
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result, action %0d", got.action));
            else
            begin
                want = expected_results.pop_front();
                check_field("action", got.action, want.action);
                check_field("action_byte", got.action_byte, want.action_byte);
                check_field("action_index", got.action_index, want.action_index);
                check_field("status", got.status, want.status);
                check_field("bytes_written", got.bytes_written, want.bytes_written);
                check_field("bytes_read", got.bytes_read, want.bytes_read);
                check_field("last", got.last, want.last);
            end
        end
        if (ready_stall != 0)
            ready_stall--;
        else if (idle_on && $urandom_range(0, 7) == 0)
            ready_stall = $urandom_range(1, 19);
        m_tready <= (ready_stall == 0);
    end

    // Watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Send one input transaction, with an optional gap in front
    task automatic send_item(in_item_t it);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {3'b000, it.rx_byte, it.bus_flags, it.receive_count, it.send_count,
                     it.tx_byte, it.tx_index};
        do @(posedge clk); while (!s_tready);
        predict_results(it);
        items_sent++;
    endtask

    task automatic load_slot(logic [3:0] idx, logic [7:0] b);
        send_item('{FN_LOAD, idx, b, 5'($urandom), 5'($urandom), 7'($urandom), 8'($urandom)});
    endtask

    task automatic begin_transfer(logic [4:0] s, logic [4:0] r);
        send_item('{FN_BEGIN, 4'($urandom), 8'($urandom), s, r, 7'($urandom), 8'($urandom)});
    endtask

    task automatic poll_bus(logic [6:0] f, logic [7:0] rx);
        send_item('{FN_POLL, 4'($urandom), 8'($urandom), 5'($urandom), 5'($urandom), f, rx});
    endtask

    // Flags that meet (or miss) the wait of the current phase
    function automatic logic [6:0] poll_flags(bit hit);
        logic [6:0] f;
        f = 7'($urandom);
        case (seq_phase)
            PH_START, PH_RESTART: f[FLAG_START]    = hit;
            PH_ADDR_W:            f[FLAG_ADDR_W]   = hit;
            PH_SENT:              f[FLAG_SENT]     = hit;
            PH_FINISH:            f[FLAG_FINISHED] = hit;
            PH_ADDR_R:            f[FLAG_ADDR_R]   = hit;
            PH_RECV:              f[FLAG_RECEIVED] = hit;
            default:              f[FLAG_BUSY]     = !hit;
        endcase
        return f;
    endfunction

    // Hold the input side until every expected result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Finish any open transfer so that configuration can change
    task automatic drain_to_idle();
        while (seq_phase != PH_IDLE)
            poll_bus(poll_flags(1'b1), 8'($urandom));
        wait_results_drained();
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MASTER_MODE:   mode_q  = val[0];
            CFG_TICK_LIMIT:    limit_q = val;
            CFG_SLAVE_ADDRESS: addr_q  = val[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [4:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 17)
            return 5'($urandom_range(0, 4));
        else if (r < 19)
            return 5'($urandom_range(5, 16));
        return 5'($urandom_range(17, 31));
    endfunction

    // Fill every queue slot, extremes first
    task automatic test_queue_load();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            load_slot(4'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
    endtask

    // Walk one write-then-read transfer and one read-only transfer
    task automatic test_write_read();
        poll_bus(7'h00, 8'h00);
        send_item('{FN_NOP, 4'hF, 8'hFF, 5'h1F, 5'h1F, 7'h7F, 8'hFF});
        begin_transfer(5'd1, 5'd2);
        poll_bus(7'h01, 8'h00);
        poll_bus(7'h00, 8'h00);
        begin_transfer(5'd9, 5'd9);
        load_slot(4'hF, 8'hFF);
        poll_bus(7'h02, 8'h00);
        poll_bus(7'h04, 8'h00);
        poll_bus(7'h08, 8'h00);
        poll_bus(7'h10, 8'h00);
        poll_bus(7'h02, 8'h00);
        poll_bus(7'h20, 8'h00);
        poll_bus(7'h40, 8'h00);
        poll_bus(7'h7F, 8'hFF);
        begin_transfer(5'd0, 5'd1);
        poll_bus(7'h00, 8'h00);
        poll_bus(7'h02, 8'h00);
        poll_bus(7'h20, 8'h00);
        poll_bus(7'h40, 8'hA5);
    endtask

    // Time out the bus-free wait and the start wait with a zero limit
    task automatic test_timeout();
        wait_results_drained();
        write_register(CFG_TICK_LIMIT, 16'd0);
        write_register(CFG_SLAVE_ADDRESS, 16'h00FF);
        begin_transfer(5'd31, 5'd31);
        poll_bus(7'h01, 8'h00);
        poll_bus(7'h7F, 8'h00);
        begin_transfer(5'd1, 5'd0);
        poll_bus(7'h00, 8'h00);
        poll_bus(7'h00, 8'h00);
        poll_bus(7'h00, 8'h00);
    endtask

    // Slave mode drops the status back to idle and clears the pending counts
    task automatic test_slave_mode();
        wait_results_drained();
        write_register(CFG_MASTER_MODE, 16'd0);
        begin_transfer(5'd3, 5'd3);
        poll_bus(7'h00, 8'h00);
        wait_results_drained();
        write_register(CFG_MASTER_MODE, 16'd1);
        poll_bus(7'h00, 8'h00);
    endtask

    // One transfer with random content, mostly well-formed flags
    task automatic run_transaction();
        int n_loads;
        int polls;
        n_loads = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n_loads) load_slot(4'($urandom), 8'($urandom));
        begin_transfer(pick_count(), pick_count());
        polls = 0;
        do
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(in_item_t'($bits(in_item_t)'({$urandom, $urandom})));
            else
                poll_bus(poll_flags($urandom_range(0, 99) < hit_pct), 8'($urandom));
            polls++;
        end
        while (seq_phase != PH_IDLE && polls < 300);
    endtask

    // Random transfers across several register settings
    task automatic test_random_traffic();
        int base;
        int mark;
        int p;
        base = items_sent;
        p    = 0;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            drain_to_idle();
            idle_on = (items_sent - base < RANDOM_ITEMS - 200) && (p % 4 != 3);
            case (p % 6)
                0:
                begin
                    write_register(CFG_TICK_LIMIT, 16'($urandom_range(0, 3)));
                    write_register(CFG_SLAVE_ADDRESS, 16'($urandom_range(0, 255)));
                    hit_pct = 75;
                end
                1:
                begin
                    write_register(CFG_TICK_LIMIT, 16'hFFFF);
                    write_register(CFG_SLAVE_ADDRESS, 16'h0000);
                    hit_pct = 70;
                end
                2:
                begin
                    write_register(CFG_TICK_LIMIT, 16'h0000);
                    write_register(CFG_SLAVE_ADDRESS, 16'h00FF);
                    hit_pct = 85;
                end
                3:
                begin
                    write_register(CFG_MASTER_MODE, 16'd0);
                    repeat (12) run_transaction();
                    drain_to_idle();
                    write_register(CFG_MASTER_MODE, 16'd1);
                    write_register(CFG_TICK_LIMIT, 16'($urandom_range(0, 10)));
                    hit_pct = 80;
                end
                4:
                begin
                    write_register(CFG_TICK_LIMIT, 16'($urandom));
                    write_register(CFG_SLAVE_ADDRESS, 16'($urandom_range(0, 255)));
                    hit_pct = 65;
                end
                default:
                begin
                    write_register(CFG_TICK_LIMIT, 16'd2);
                    hit_pct = 60;
                end
            endcase
            mark = items_sent;
            while (items_sent - mark < PHASE_ITEMS && items_sent - base < RANDOM_ITEMS)
            begin
                if (items_sent - base >= RANDOM_ITEMS - 200)
                    idle_on = 1'b0;
                run_transaction();
            end
            p++;
        end
    endtask

    // Reset, run the tests in turn, report
    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;

        mode_q    = MASTER_MODE_RST;
        limit_q   = TICK_LIMIT_RST;
        addr_q    = SLAVE_ADDRESS_RST;
        seq_phase = PH_IDLE;
        ticks     = '0;
        want_send = '0;
        want_recv = '0;
        pos       = '0;
        status_q  = ST_IDLE;
        wr_cnt    = '0;
        rd_cnt    = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_queue_load();
        test_write_read();
        test_timeout();
        test_slave_mode();
        test_random_traffic();

        idle_on = 1'b0;
        wait_results_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
